[rtl/core/bcpp_pkg.sv]
// Shared types, constants and microcode program of the cascaded balance controller.
package bcpp_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SPEED_SETPOINT = 3'd0,
    REG_SPEED_GAIN_P   = 3'd1,
    REG_SPEED_GAIN_I   = 3'd2,
    REG_TILT_GAIN_P    = 3'd3,
    REG_TILT_GAIN_D    = 3'd4,
    REG_BALANCE_ANGLE  = 3'd5
  } reg_index_t;

  // Register reset values.
  localparam logic signed [14:0] SPEED_SETPOINT_RESET = 15'sd960;
  localparam logic signed [31:0] SPEED_GAIN_P_RESET   = 32'sd78643;
  localparam logic signed [31:0] SPEED_GAIN_I_RESET   = 32'sd367;
  localparam logic signed [31:0] TILT_GAIN_P_RESET    = -32'sd73400320;
  localparam logic signed [31:0] TILT_GAIN_D_RESET    = -32'sd125829120;
  localparam logic signed [15:0] BALANCE_ANGLE_RESET  = -16'sd550;

  // Saturation limits and thresholds.
  localparam logic signed [20:0] INTEG_LIMIT      = 21'sd800000;
  localparam logic signed [10:0] CORR_LIMIT       = 11'sd1000;
  localparam logic signed [10:0] MOTOR_LIMIT      = 11'sd1000;
  localparam logic signed [16:0] DEADBAND_ERR     = 17'sd32;
  localparam logic signed [14:0] DEADBAND_SET     = 15'sd1;
  localparam logic signed [15:0] SEPARATION_ANGLE = 16'sd2000;
  // Motor magnitude at or above this, after the 2^20 shift, saturates.
  localparam logic [39:0]        MOTOR_SAT_LEVEL  = 40'd1600000;

  // Multiplier constants: percent scale and reciprocals for /10, 4/5 and /25.
  localparam logic signed [31:0] K_HUNDRED = 32'sd100;
  localparam logic signed [31:0] RECIP_10  = 32'sd838861;   // 2^23 / 10, rounded up
  localparam logic signed [31:0] RECIP_5   = 32'sd6710887;  // 2^25 / 5, rounded up
  localparam logic signed [31:0] RECIP_25  = 32'sd41944;    // 2^20 / 25, rounded up

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  // Multiplier operand A source.
  typedef enum logic [2:0] {
    MA_K100, MA_RECIP10, MA_RECIP5, MA_RECIP25, MA_KP, MA_KI, MA_TP, MA_TD
  } mul_a_sel_t;

  // Multiplier operand B source.
  typedef enum logic [3:0] {
    MB_RATE, MB_T_MAG, MB_SI_MAG, MB_FE, MB_SI, MB_T, MB_U, MB_R100, MB_Z
  } mul_b_sel_t;

  // Register write-back operation of a step.
  typedef enum logic [3:0] {
    OP_NOP, OP_MIX, OP_R100, OP_FE, OP_SI_STEP, OP_SI_DECAY, OP_T_PROD, OP_U_PROD,
    OP_ACC_LOAD, OP_ACC_ADD, OP_ACC_ABS, OP_CORR, OP_ERR, OP_ACC_X16,
    OP_MOTOR_SAT, OP_MOTOR
  } op_t;

  // Jump condition of a step.
  typedef enum logic [1:0] {
    JC_NONE, JC_NOT_DECAY, JC_SAT
  } cond_t;

  typedef struct packed {
    mul_a_sel_t mul_a;
    mul_b_sel_t mul_b;
    op_t        op;
    cond_t      cond;
    step_t      target;
    logic       last;
  } ucode_t;

  // Control store. A product issued in one step is written back in the next.
  function automatic ucode_t ucode_rom(input step_t idx);
    ucode_t w;
    w = '{MA_K100, MB_RATE, OP_NOP, JC_NONE, step_t'(0), 1'b1};
    unique case (idx)
      5'd0:  w = '{MA_K100,    MB_RATE,   OP_MIX,       JC_NONE,      5'd0,  1'b0};
      5'd1:  w = '{MA_RECIP10, MB_T_MAG,  OP_R100,      JC_NONE,      5'd0,  1'b0};
      5'd2:  w = '{MA_K100,    MB_RATE,   OP_FE,        JC_NONE,      5'd0,  1'b0};
      5'd3:  w = '{MA_RECIP5,  MB_SI_MAG, OP_SI_STEP,   JC_NOT_DECAY, 5'd5,  1'b0};
      5'd4:  w = '{MA_K100,    MB_RATE,   OP_SI_DECAY,  JC_NONE,      5'd0,  1'b0};
      5'd5:  w = '{MA_K100,    MB_FE,     OP_NOP,       JC_NONE,      5'd0,  1'b0};
      5'd6:  w = '{MA_K100,    MB_SI,     OP_T_PROD,    JC_NONE,      5'd0,  1'b0};
      5'd7:  w = '{MA_KP,      MB_T,      OP_U_PROD,    JC_NONE,      5'd0,  1'b0};
      5'd8:  w = '{MA_KI,      MB_U,      OP_ACC_LOAD,  JC_NONE,      5'd0,  1'b0};
      5'd9:  w = '{MA_K100,    MB_RATE,   OP_ACC_ADD,   JC_NONE,      5'd0,  1'b0};
      5'd10: w = '{MA_K100,    MB_RATE,   OP_ACC_ABS,   JC_NONE,      5'd0,  1'b0};
      5'd11: w = '{MA_K100,    MB_RATE,   OP_CORR,      JC_NONE,      5'd0,  1'b0};
      5'd12: w = '{MA_K100,    MB_RATE,   OP_ERR,       JC_NONE,      5'd0,  1'b0};
      5'd13: w = '{MA_TP,      MB_T,      OP_NOP,       JC_NONE,      5'd0,  1'b0};
      5'd14: w = '{MA_TD,      MB_R100,   OP_ACC_X16,   JC_NONE,      5'd0,  1'b0};
      5'd15: w = '{MA_K100,    MB_RATE,   OP_ACC_ADD,   JC_NONE,      5'd0,  1'b0};
      5'd16: w = '{MA_K100,    MB_RATE,   OP_ACC_ABS,   JC_NONE,      5'd0,  1'b0};
      5'd17: w = '{MA_RECIP25, MB_Z,      OP_MOTOR_SAT, JC_SAT,       5'd19, 1'b0};
      5'd18: w = '{MA_K100,    MB_RATE,   OP_MOTOR,     JC_NONE,      5'd0,  1'b0};
      5'd19: w = '{MA_K100,    MB_RATE,   OP_NOP,       JC_NONE,      5'd0,  1'b1};
      default: w = '{MA_K100,  MB_RATE,   OP_NOP,       JC_NONE,      5'd0,  1'b1};
    endcase
    return w;
  endfunction

endpackage

[rtl/core/balance_cascade_pi_pd_unit.sv]
// Cascaded speed PI / tilt PD balance controller driven by a microcoded sequencer.
//
//  channel  | signals                               | beat carries
//  ---------+---------------------------------------+-------------------------------
//  s_axis   | s_axis_tvalid/tready/tdata[47:0]      | tilt_angle, tilt_rate, speed
//  m_axis   | m_axis_tvalid/tready/tdata[23:0]      | motor_speed, angle_correction
//  cfg      | cfg_valid/ready/index[2:0]/data[31:0] | one register write
//
// A sample runs through a 20-step program, whose conditional jumps can skip steps, and the
// input takes no new beat until it is done; the single shared 32x28 multiplier, used once
// per step, is why the work is spread over the steps.
// The last step waits while a previous result still sits unaccepted on m_axis.
// Reset is synchronous; it restores the register defaults and clears the
// filtered error and speed integral. cfg_ready is always high.
module balance_cascade_pi_pd_unit
  import bcpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Fields from bit 0: tilt_angle[15:0], tilt_rate[31:16], wheel_speed[47:32].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  // Fields from bit 0: motor_speed[10:0], angle_correction[21:11], zero pad[23:22].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers.
  logic signed [14:0] speed_setpoint;
  logic signed [31:0] speed_gain_p;
  logic signed [31:0] speed_gain_i;
  logic signed [31:0] tilt_gain_p;
  logic signed [31:0] tilt_gain_d;
  logic signed [15:0] balance_angle;

  // Sequencer.
  logic   busy;
  step_t  step;
  ucode_t uc;
  logic   jump;
  logic   emit;

  // Sample and datapath registers.
  logic signed [15:0] tilt_angle;
  logic signed [15:0] tilt_rate;
  logic signed [15:0] wheel_speed;
  logic signed [16:0] filtered_error;
  logic signed [20:0] integ_sum;
  logic signed [23:0] t;
  logic signed [27:0] u;
  logic signed [22:0] r100;
  logic signed [59:0] acc;
  logic               neg;
  logic signed [10:0] corr;
  logic signed [10:0] motor;
  logic signed [59:0] prod;
  logic signed [10:0] out_motor;
  logic signed [10:0] out_corr;

  // Combinational datapath values.
  logic signed [16:0] speed_diff;
  logic signed [19:0] e20;
  logic signed [19:0] fe20;
  logic signed [19:0] mix;
  logic        [23:0] t_mag;
  logic        [20:0] si_mag;
  logic signed [16:0] fe_mag;
  logic signed [16:0] fe_new;
  logic signed [20:0] decay_mag;
  logic signed [20:0] si_decay;
  logic               decay;
  logic               separate;
  logic signed [21:0] si_sum;
  logic signed [20:0] si_clamped;
  logic signed [20:0] si_step;
  logic signed [10:0] corr_lim;
  logic signed [10:0] corr_new;
  logic signed [17:0] err;
  logic               motor_sat;
  logic        [14:0] z;
  logic signed [10:0] motor_q;
  logic signed [59:0] acc_abs;
  logic signed [31:0] mul_a;
  logic signed [27:0] mul_b;
  logic signed [59:0] mul_full;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !busy;
  assign m_axis_tdata  = {2'b00, out_corr, out_motor};
  assign uc            = ucode_rom(step);

  // The last step hands its result over once the output register is free.
  assign emit = busy && uc.last && (!m_axis_tvalid || m_axis_tready);

  // Speed error mix: 7*e + 3*filtered_error.
  assign speed_diff = 17'(speed_setpoint) - 17'(wheel_speed);
  assign e20        = 20'(speed_diff);
  assign fe20       = 20'(filtered_error);
  assign mix        = (e20 <<< 3) - e20 + (fe20 <<< 1) + fe20;

  // Magnitudes for the reciprocal multiplies.
  assign t_mag  = t[23] ? 24'(-t) : 24'(t);
  assign si_mag = integ_sum[20] ? 21'(-integ_sum) : 21'(integ_sum);

  // Quotient by ten, sign restored to truncate toward zero.
  assign fe_mag = {1'b0, prod[38:23]};
  assign fe_new = t[23] ? -fe_mag : fe_mag;

  // Integral decay by four fifths, truncated toward zero.
  assign decay_mag = {1'b0, prod[42:23]};
  assign si_decay  = integ_sum[20] ? -decay_mag : decay_mag;

  // Integral mode selection.
  assign decay = (filtered_error > -DEADBAND_ERR) && (filtered_error < DEADBAND_ERR) &&
                 (speed_setpoint >= -DEADBAND_SET) && (speed_setpoint <= DEADBAND_SET);
  assign separate = (tilt_angle >= SEPARATION_ANGLE) || (tilt_angle <= -SEPARATION_ANGLE);

  // Accumulate with clamp, or zero at or beyond the separation angle.
  assign si_sum = 22'(integ_sum) + 22'(filtered_error);
  always_comb begin
    if (si_sum > 22'(INTEG_LIMIT)) begin
      si_clamped = INTEG_LIMIT;
    end else if (si_sum < -22'(INTEG_LIMIT)) begin
      si_clamped = -INTEG_LIMIT;
    end else begin
      si_clamped = 21'(si_sum);
    end
  end
  assign si_step = separate ? '0 : si_clamped;

  // Angle correction from the magnitude in acc, scaled by 2^-24.
  assign corr_lim = (acc[59:24] > 36'd1000) ? CORR_LIMIT : $signed({1'b0, acc[33:24]});
  assign corr_new = neg ? -corr_lim : corr_lim;

  // Upright loop angle error.
  assign err = 18'(tilt_angle) - (18'(balance_angle) + 18'(corr));

  // Motor command from the magnitude in acc: /2^26 then /25 by reciprocal.
  assign motor_sat = acc[59:20] >= MOTOR_SAT_LEVEL;
  assign z         = acc[40:26];
  assign motor_q   = $signed({1'b0, prod[29:20]});

  assign acc_abs = acc[59] ? -acc : acc;

  // Shared multiplier operand selection.
  always_comb begin
    unique case (uc.mul_a)
      MA_K100:    mul_a = K_HUNDRED;
      MA_RECIP10: mul_a = RECIP_10;
      MA_RECIP5:  mul_a = RECIP_5;
      MA_RECIP25: mul_a = RECIP_25;
      MA_KP:      mul_a = speed_gain_p;
      MA_KI:      mul_a = speed_gain_i;
      MA_TP:      mul_a = tilt_gain_p;
      MA_TD:      mul_a = tilt_gain_d;
    endcase
  end

  always_comb begin
    unique case (uc.mul_b)
      MB_RATE:   mul_b = 28'(tilt_rate);
      MB_T_MAG:  mul_b = $signed({4'b0000, t_mag});
      MB_SI_MAG: mul_b = $signed({7'b0000000, si_mag});
      MB_FE:     mul_b = 28'(filtered_error);
      MB_SI:     mul_b = 28'(integ_sum);
      MB_T:      mul_b = 28'(t);
      MB_U:      mul_b = u;
      MB_R100:   mul_b = 28'(r100);
      MB_Z:      mul_b = $signed({13'd0, z});
      default:   mul_b = '0;
    endcase
  end

  assign mul_full = 60'(mul_a) * 60'(mul_b);

  // Conditional jump of the current step.
  always_comb begin
    case (uc.cond)
      JC_NOT_DECAY: jump = !decay;
      JC_SAT:       jump = motor_sat;
      default:      jump = 1'b0;
    endcase
  end

  // Sequencer, output beat and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      step           <= '0;
      m_axis_tvalid  <= 1'b0;
      speed_setpoint <= SPEED_SETPOINT_RESET;
      speed_gain_p   <= SPEED_GAIN_P_RESET;
      speed_gain_i   <= SPEED_GAIN_I_RESET;
      tilt_gain_p    <= TILT_GAIN_P_RESET;
      tilt_gain_d    <= TILT_GAIN_D_RESET;
      balance_angle  <= BALANCE_ANGLE_RESET;
    end else begin
      if (!busy) begin
        if (s_axis_tvalid) begin
          busy <= 1'b1;
          step <= '0;
        end
      end else if (uc.last) begin
        if (emit) begin
          busy <= 1'b0;
          step <= '0;
        end
      end else begin
        step <= jump ? uc.target : step + step_t'(1);
      end
      // Result beat: load a new one, or drop valid once the old one is taken.
      if (emit) begin
        m_axis_tvalid <= 1'b1;
        out_motor     <= motor;
        out_corr      <= corr;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SPEED_SETPOINT: speed_setpoint <= cfg_data[14:0];
          REG_SPEED_GAIN_P:   speed_gain_p   <= cfg_data;
          REG_SPEED_GAIN_I:   speed_gain_i   <= cfg_data;
          REG_TILT_GAIN_P:    tilt_gain_p    <= cfg_data;
          REG_TILT_GAIN_D:    tilt_gain_d    <= cfg_data;
          REG_BALANCE_ANGLE:  balance_angle  <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers, written by the op of the current step.
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_error <= '0;
      integ_sum      <= '0;
    end else if (!busy) begin
      if (s_axis_tvalid) begin
        tilt_angle  <= s_axis_tdata[15:0];
        tilt_rate   <= s_axis_tdata[31:16];
        wheel_speed <= s_axis_tdata[47:32];
      end
    end else begin
      prod <= mul_full;
      unique case (uc.op)
        OP_NOP:       ;
        OP_MIX:       t <= 24'(mix);
        OP_R100:      r100 <= prod[22:0];
        OP_FE:        filtered_error <= fe_new;
        OP_SI_STEP: begin
          if (!decay) begin
            integ_sum <= si_step;
          end
        end
        OP_SI_DECAY:  integ_sum <= si_decay;
        OP_T_PROD:    t <= prod[23:0];
        OP_U_PROD:    u <= prod[27:0];
        OP_ACC_LOAD:  acc <= prod;
        OP_ACC_ADD:   acc <= acc + prod;
        OP_ACC_ABS: begin
          acc <= acc_abs;
          neg <= acc[59];
        end
        OP_CORR:      corr <= corr_new;
        OP_ERR:       t <= 24'(err);
        OP_ACC_X16:   acc <= prod <<< 4;
        OP_MOTOR_SAT: begin
          if (motor_sat) begin
            motor <= neg ? -MOTOR_LIMIT : MOTOR_LIMIT;
          end
        end
        OP_MOTOR:     motor <= neg ? -motor_q : motor_q;
      endcase
    end
  end

endmodule

[rtl/core/bcpp_checker.sv]
// Port-level checks for the balance controller, bound to its top level.
module bcpp_checker
  import bcpp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A stalled result beat holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // The motor command stays inside its saturation limits.
  a_motor_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[10:0]) <= MOTOR_LIMIT) &&
                      ($signed(m_axis_tdata[10:0]) >= -MOTOR_LIMIT))
    else $error("motor_speed outside its limits");

  // The angle correction stays inside its saturation limits.
  a_corr_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[21:11]) <= CORR_LIMIT) &&
                      ($signed(m_axis_tdata[21:11]) >= -CORR_LIMIT))
    else $error("angle_correction outside its limits");

  // Pad bits of the result beat are zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:22] == 2'b00)
    else $error("result pad bits not zero");

  // A sample keeps the block busy, so no input beat follows directly.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again right after a beat");

endmodule

bind balance_cascade_pi_pd_unit bcpp_checker u_bcpp_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the cascaded speed PI / tilt PD balance controller.
module tb_top;
  import bcpp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 1900;
  localparam int NUM_REGS       = 6;

  // Controller limits and thresholds used by the predictor.
  localparam longint SI_LIMIT       = 800000;
  localparam longint CORR_MAX       = 1000;
  localparam longint MOTOR_MAX      = 1000;
  localparam longint DECAY_ERR_BAND = 32;
  localparam longint DECAY_SET_BAND = 1;
  localparam longint TIP_ANGLE      = 2000;
  localparam longint CORR_DIVISOR   = 64'sd16777216;
  localparam longint MOTOR_DIVISOR  = 64'sd1677721600;

  // Register indexes past the end of the map; writes to them are dropped.
  localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

  typedef enum int {RUN_TRACK, RUN_RUNAWAY, RUN_NOISE} run_kind_t;

  typedef struct packed {
    logic signed [10:0] motor;
    logic signed [10:0] correction;
  } command_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Predictor copy of the register file and loop state.
  logic signed [14:0] ctl_setpoint = SPEED_SETPOINT_RESET;
  logic signed [31:0] ctl_speed_kp = SPEED_GAIN_P_RESET;
  logic signed [31:0] ctl_speed_ki = SPEED_GAIN_I_RESET;
  logic signed [31:0] ctl_tilt_kp  = TILT_GAIN_P_RESET;
  logic signed [31:0] ctl_tilt_kd  = TILT_GAIN_D_RESET;
  logic signed [15:0] ctl_balance  = BALANCE_ANGLE_RESET;
  longint             est_filtered_error = 0;
  longint             est_integral = 0;

  command_t    expected_commands[$];
  logic [31:0] pending_regs [NUM_REGS];
  bit          idle_on = 1'b0;
  int          sink_hold = 0;
  int          mismatches = 0;

  balance_cascade_pi_pd_unit uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Advance the loop state by one sample and return the command it produces.
  function automatic command_t compute_command(logic signed [15:0] angle,
                                               logic signed [15:0] rate,
                                               logic signed [15:0] speed);
    longint   setpoint, corr, tilt_err, motor;
    command_t cmd;
    setpoint = ctl_setpoint;
    est_filtered_error = (7 * (setpoint - speed) + 3 * est_filtered_error) / 10;

    // Integral decays near standstill, clears when tipped over, else accumulates.
    if (magnitude(est_filtered_error) < DECAY_ERR_BAND &&
        magnitude(setpoint) <= DECAY_SET_BAND)
      est_integral = (4 * est_integral) / 5;
    else if (magnitude(angle) < TIP_ANGLE)
      est_integral = est_integral + est_filtered_error;
    else
      est_integral = 0;
    est_integral = clamp_mag(est_integral, SI_LIMIT);

    corr = (longint'(ctl_speed_kp) * est_filtered_error +
            longint'(ctl_speed_ki) * est_integral) * 100 / CORR_DIVISOR;
    corr = clamp_mag(corr, CORR_MAX);

    tilt_err = angle - (longint'(ctl_balance) + corr);
    motor = (longint'(ctl_tilt_kp) * tilt_err * 16 +
             longint'(ctl_tilt_kd) * rate * 100) / MOTOR_DIVISOR;
    motor = clamp_mag(motor, MOTOR_MAX);

    cmd.motor = 11'(motor);
    cmd.correction = 11'(corr);
    return cmd;
  endfunction

  function automatic logic [31:0] reset_value(int idx);
    case (idx)
      REG_SPEED_SETPOINT: return 32'(SPEED_SETPOINT_RESET);
      REG_SPEED_GAIN_P:   return SPEED_GAIN_P_RESET;
      REG_SPEED_GAIN_I:   return SPEED_GAIN_I_RESET;
      REG_TILT_GAIN_P:    return TILT_GAIN_P_RESET;
      REG_TILT_GAIN_D:    return TILT_GAIN_D_RESET;
      REG_BALANCE_ANGLE:  return 32'(BALANCE_ANGLE_RESET);
      default:            return '0;
    endcase
  endfunction

  // Random register value: defaults, extremes, raw random words, near-standstill setpoints, shifted or scaled values.
  function automatic logic [31:0] pick_value(int idx);
    int          choice;
    logic [31:0] base;
    choice = $urandom_range(0, 7);
    base = reset_value(idx);
    if (choice == 0) return base;
    if (choice == 7) return $urandom();
    case (idx)
      REG_SPEED_SETPOINT:
        case (choice)
          1:       return 32'hFFFF_C000;
          2:       return 32'h0000_3FFF;
          3, 4:    return 32'($urandom_range(0, 2)) - 32'd1;
          default: return 32'($urandom_range(0, 4000)) - 32'd2000;
        endcase
      REG_BALANCE_ANGLE:
        case (choice)
          1:       return 32'hFFFF_8000;
          2:       return 32'h0000_7FFF;
          default: return base + 32'($urandom_range(0, 2000)) - 32'd1000;
        endcase
      default:
        case (choice)
          1:       return 32'h8000_0000;
          2:       return 32'h7FFF_FFFF;
          3:       return -base;
          default: return 32'($signed(base) * int'($urandom_range(1, 6)) / 4);
        endcase
    endcase
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    if (mismatches < MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // One register write; cfg_valid is left high for back-to-back writes.
  task automatic write_register(logic [2:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SPEED_SETPOINT: ctl_setpoint = value[14:0];
      REG_SPEED_GAIN_P:   ctl_speed_kp = value;
      REG_SPEED_GAIN_I:   ctl_speed_ki = value;
      REG_TILT_GAIN_P:    ctl_tilt_kp  = value;
      REG_TILT_GAIN_D:    ctl_tilt_kd  = value;
      REG_BALANCE_ANGLE:  ctl_balance  = value[15:0];
      default: ;
    endcase
  endtask

  // Write the whole register file from pending_regs, sometimes with a stray index too.
  task automatic load_settings();
    for (int i = 0; i < NUM_REGS; i++) write_register(3'(i), pending_regs[i]);
    if ($urandom_range(0, 3) == 0)
      write_register($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, $urandom());
    cfg_valid <= 1'b0;
  endtask

  // Offer one sample beat and record the command it must produce.
  task automatic send_sample(logic [15:0] angle, logic [15:0] rate, logic [15:0] speed);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {speed, rate, angle};
    do @(posedge clk); while (!s_axis_tready);
    expected_commands.push_back(compute_command(angle, rate, speed));
  endtask

  task automatic send_random_sample();
    send_sample(16'($urandom_range(0, 4000)) - 16'd2000, $urandom(), $urandom());
  endtask

  // Stop offering and wait until every outstanding command has come back.
  task automatic wait_commands_done();
    s_axis_tvalid <= 1'b0;
    while (expected_commands.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    // Just inside the tip angle the integral accumulates; at it, the integral clears.
    send_sample(16'sd1999, -16'sd300, 16'sd960);
    send_sample(-16'sd2000, 16'sd300, -16'sd500);
    send_sample(16'sd2000, 16'sd0, 16'sd5000);
    wait_commands_done();
  endtask

  task automatic test_integral_decay();
    // Build up some integral with a zero setpoint, then let the error die away.
    foreach (pending_regs[i]) pending_regs[i] = reset_value(i);
    pending_regs[REG_SPEED_SETPOINT] = 32'd0;
    pending_regs[REG_SPEED_GAIN_I]   = 32'h0000_4000;
    load_settings();
    repeat (3) send_sample(16'sd150, 16'sd40, -16'sd3000);
    repeat (6) send_sample(16'sd150, -16'sd40, 16'sd0);
    wait_commands_done();

    // Setpoint of minus one still counts as standstill.
    pending_regs[REG_SPEED_SETPOINT] = 32'hFFFF_FFFF;
    load_settings();
    repeat (2) send_sample(-16'sd80, 16'sd10, -16'sd1);
    wait_commands_done();

    // Setpoint of two does not, so the integral accumulates again.
    pending_regs[REG_SPEED_SETPOINT] = 32'd2;
    load_settings();
    send_sample(-16'sd80, 16'sd10, 16'sd2);
    wait_commands_done();
  endtask

  task automatic test_saturation();
    foreach (pending_regs[i]) pending_regs[i] = reset_value(i);
    pending_regs[REG_SPEED_GAIN_P]  = 32'h7FFF_FFFF;
    pending_regs[REG_TILT_GAIN_P]   = 32'h8000_0000;
    pending_regs[REG_TILT_GAIN_D]   = 32'h7FFF_FFFF;
    pending_regs[REG_BALANCE_ANGLE] = 32'hFFFF_8000;
    write_register(REG_UNMAPPED_HI, 32'hFFFF_FFFF);
    load_settings();
    send_sample(16'sd100, 16'h7FFF, 16'h8000);
    send_sample(-16'sd100, 16'h8000, 16'h7FFF);
    wait_commands_done();

    // Most negative setpoint, with the unused upper data bits left clear.
    pending_regs[REG_SPEED_SETPOINT] = 32'h0000_4000;
    pending_regs[REG_SPEED_GAIN_P]   = 32'h8000_0000;
    pending_regs[REG_SPEED_GAIN_I]   = 32'h8000_0000;
    pending_regs[REG_TILT_GAIN_P]    = 32'h7FFF_FFFF;
    pending_regs[REG_TILT_GAIN_D]    = 32'h8000_0000;
    pending_regs[REG_BALANCE_ANGLE]  = 32'h0000_7FFF;
    write_register(REG_UNMAPPED_LO, 32'h0000_0000);
    load_settings();
    send_sample(16'sd500, 16'h8000, 16'h7FFF);
    send_sample(-16'sd500, 16'h7FFF, 16'h8000);
    wait_commands_done();
  endtask

  task automatic test_output_backpressure();
    // Hold the result side off long enough for the input to stall.
    foreach (pending_regs[i]) pending_regs[i] = reset_value(i);
    load_settings();
    idle_on = 1'b0;
    sink_hold = HOLD_CYCLES;
    repeat (12) send_random_sample();
    wait_commands_done();
  endtask

  task automatic test_sender_pause();
    idle_on = 1'b1;
    repeat (6) send_random_sample();
    wait_commands_done();
    repeat (6) send_random_sample();
    wait_commands_done();
  endtask

  // Runs of tracking, runaway and noise samples under random register settings.
  task automatic test_random_traffic(int count);
    int          sent, phase_left, run_left;
    run_kind_t   run_kind;
    logic [15:0] angle, rate, speed, run_speed;
    sent = 0;
    phase_left = 0;
    run_left = 0;
    run_kind = RUN_TRACK;
    run_speed = '0;
    while (sent < count) begin
      if (phase_left == 0) begin
        wait_commands_done();
        foreach (pending_regs[i]) pending_regs[i] = pick_value(i);
        load_settings();
        phase_left = $urandom_range(30, 90);
        idle_on = (sent < count * 4 / 5) && ($urandom_range(0, 3) != 0);
      end
      if (run_left == 0) begin
        run_kind = run_kind_t'($urandom_range(0, 2));
        run_left = (run_kind == RUN_RUNAWAY) ? $urandom_range(25, 40) : $urandom_range(4, 20);
        run_speed = $urandom_range(0, 1) ? 16'h7FFF - 16'($urandom_range(0, 3000))
                                         : 16'h8000 + 16'($urandom_range(0, 3000));
      end

      rate = 16'($urandom_range(0, 4000)) - 16'd2000;
      case (run_kind)
        RUN_TRACK: begin
          angle = 16'($urandom_range(0, 4600)) - 16'd2300;
          speed = 16'(ctl_setpoint) + 16'($urandom_range(0, 80)) - 16'd40;
        end
        RUN_RUNAWAY: begin
          // Stay upright so the integral can wind up to its clamp.
          angle = 16'($urandom_range(0, 3800)) - 16'd1900;
          speed = run_speed + 16'($urandom_range(0, 40)) - 16'd20;
        end
        default: begin
          angle = $urandom();
          rate  = $urandom();
          speed = $urandom();
        end
      endcase
      if ($urandom_range(0, 15) == 0) rate = $urandom();
      if (run_kind != RUN_RUNAWAY && $urandom_range(0, 19) == 0) begin
        angle = 16'd2000 - 16'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) angle = -angle;
      end

      send_sample(angle, rate, speed);
      sent++;
      phase_left--;
      run_left--;
    end
    wait_commands_done();
  endtask

  // Result side: random ready bursts, a long hold on request, and the field check.
  initial begin : command_monitor
    int       burst;
    command_t want, got;
    burst = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.motor      = m_axis_tdata[10:0];
        got.correction = m_axis_tdata[21:11];
        if (expected_commands.size() == 0) begin
          report_mismatch("result beat with nothing expected, tdata", 0, m_axis_tdata);
        end else begin
          want = expected_commands.pop_front();
          if (got.motor !== want.motor)
            report_mismatch("motor_speed", want.motor, got.motor);
          if (got.correction !== want.correction)
            report_mismatch("angle_correction", want.correction, got.correction);
        end
      end

      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        if (burst == 0 && idle_on && $urandom_range(0, 5) == 0)
          burst = $urandom_range(1, 3);
        if (burst > 0) begin
          burst--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // End the run if nothing moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("balance_cascade_pi_pd_unit test failed");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_integral_decay();
    test_saturation();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic(RANDOM_ITEMS);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_commands.size() == 0)
      $display("balance_cascade_pi_pd_unit test passed");
    else
      $display("balance_cascade_pi_pd_unit test failed");
    $finish;
  end

endmodule

[files.f]
rtl/core/bcpp_pkg.sv
rtl/core/balance_cascade_pi_pd_unit.sv
rtl/core/bcpp_checker.sv
tb/tb_top.sv
